// ----- hdl/uhcr_pkg.sv -----
// uhcr_pkg: shared types, codes, microprogram and constant tables of the
// hid control responder. No dependencies.
`default_nettype none

package uhcr_pkg;

    localparam int STEP_W = 3;
    localparam int POS_W  = 7;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_SMALL   = 2'd2;

    localparam logic [1:0] RT_STANDARD = 2'd0;
    localparam logic [1:0] RT_CLASS    = 2'd1;
    localparam logic [1:0] RCP_INTERFACE = 2'd1;

    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
    localparam logic [7:0] REQ_GET_REPORT     = 8'h01;
    localparam logic [7:0] REQ_GET_IDLE       = 8'h02;
    localparam logic [7:0] REQ_GET_PROTOCOL   = 8'h03;
    localparam logic [7:0] REQ_SET_REPORT     = 8'h09;
    localparam logic [7:0] REQ_SET_IDLE       = 8'h0A;
    localparam logic [7:0] REQ_SET_PROTOCOL   = 8'h0B;

    localparam logic [7:0] DESC_REPORT    = 8'h22;
    localparam logic [7:0] REPORT_FEATURE = 8'h03;

    localparam logic [7:0] MSG_PRODUCT_ID = 8'h83;
    localparam logic [7:0] MSG_SERIAL     = 8'hAE;

    localparam logic [1:0] KIND_ZERO   = 2'd0;
    localparam logic [1:0] KIND_ACK    = 2'd1;
    localparam logic [1:0] KIND_PID    = 2'd2;
    localparam logic [1:0] KIND_SERIAL = 2'd3;

    localparam logic [1:0] SRC_ROM0  = 2'd0;
    localparam logic [1:0] SRC_ROM1  = 2'd1;
    localparam logic [1:0] SRC_ROM2  = 2'd2;
    localparam logic [1:0] SRC_REPLY = 2'd3;

    localparam logic [15:0] ROM0_LEN = 16'd39;
    localparam logic [15:0] ROM1_LEN = 16'd65;
    localparam logic [15:0] ROM2_LEN = 16'd29;

    localparam logic [15:0] PRODUCT_ID_RESET = 16'h1205;

    localparam logic [7:0] ROM_IF0 [0:38] = '{
        8'h05, 8'h01, 8'h09, 8'h06, 8'hA1, 8'h01, 8'h05, 8'h07, 8'h19, 8'hE0, 8'h29, 8'hE7,
        8'h15, 8'h00, 8'h25, 8'h01, 8'h75, 8'h01, 8'h95, 8'h08, 8'h81, 8'h02, 8'h81, 8'h01,
        8'h19, 8'h00, 8'h29, 8'h65, 8'h15, 8'h00, 8'h25, 8'h65, 8'h75, 8'h08, 8'h95, 8'h06,
        8'h81, 8'h00, 8'hC0
    };

    localparam logic [7:0] ROM_IF1 [0:64] = '{
        8'h05, 8'h01, 8'h09, 8'h02, 8'hA1, 8'h01, 8'h09, 8'h01, 8'hA1, 8'h00, 8'h05, 8'h09,
        8'h19, 8'h01, 8'h29, 8'h02, 8'h15, 8'h00, 8'h25, 8'h01, 8'h75, 8'h01, 8'h95, 8'h02,
        8'h81, 8'h02, 8'h75, 8'h06, 8'h95, 8'h01, 8'h81, 8'h01, 8'h05, 8'h01, 8'h09, 8'h30,
        8'h09, 8'h31, 8'h15, 8'h81, 8'h25, 8'h7F, 8'h75, 8'h08, 8'h95, 8'h02, 8'h81, 8'h06,
        8'h95, 8'h01, 8'h09, 8'h38, 8'h81, 8'h06, 8'h05, 8'h0C, 8'h0A, 8'h38, 8'h02, 8'h95,
        8'h01, 8'h81, 8'h06, 8'hC0, 8'hC0
    };

    localparam logic [7:0] ROM_IF2 [0:28] = '{
        8'h06, 8'hFF, 8'hFF, 8'h09, 8'h01, 8'hA1, 8'h01, 8'h15, 8'h00, 8'h26, 8'hFF, 8'h00,
        8'h75, 8'h08, 8'h95, 8'h40, 8'h09, 8'h01, 8'h81, 8'h02, 8'h09, 8'h01, 8'h91, 8'h02,
        8'h09, 8'h01, 8'hB1, 8'h02, 8'hC0
    };

    localparam logic [7:0] SERIAL_TEXT [0:11] = '{
        8'h4D, 8'h45, 8'h44, 8'h41, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h31
    };

    typedef enum logic [1:0] {
        GATE_NONE,
        GATE_IN,
        GATE_OUT
    } gate_t;

    typedef enum logic [2:0] {
        ACT_NOP,
        ACT_CAPTURE,
        ACT_DECODE,
        ACT_EMIT_ONE,
        ACT_EMIT_WORD
    } act_t;

    typedef enum logic [1:0] {
        BR_NEVER,
        BR_ALWAYS,
        BR_STREAM,
        BR_MORE
    } br_t;

    typedef struct packed {
        gate_t             gate;
        act_t              act;
        br_t               br;
        logic [STEP_W-1:0] target;
    } ctl_word_t;

    typedef struct packed {
        act_t act;
        logic go;
    } seq_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic stream;
        logic more;
    } seq_flags_t;

    localparam logic [STEP_W-1:0] STEP_CAPTURE = 3'd0;
    localparam logic [STEP_W-1:0] STEP_DECODE  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_BRANCH  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_ONE     = 3'd3;
    localparam logic [STEP_W-1:0] STEP_WORD    = 3'd4;
    localparam logic [STEP_W-1:0] STEP_DONE    = 3'd5;

    function automatic ctl_word_t ucode(input logic [STEP_W-1:0] step);
        ctl_word_t w;
        unique case (step)
            STEP_CAPTURE: w = '{GATE_IN,   ACT_CAPTURE,   BR_ALWAYS, STEP_DECODE};
            STEP_DECODE:  w = '{GATE_NONE, ACT_DECODE,    BR_NEVER,  STEP_CAPTURE};
            STEP_BRANCH:  w = '{GATE_NONE, ACT_NOP,       BR_STREAM, STEP_WORD};
            STEP_ONE:     w = '{GATE_OUT,  ACT_EMIT_ONE,  BR_ALWAYS, STEP_CAPTURE};
            STEP_WORD:    w = '{GATE_OUT,  ACT_EMIT_WORD, BR_MORE,   STEP_WORD};
            STEP_DONE:    w = '{GATE_NONE, ACT_NOP,       BR_ALWAYS, STEP_CAPTURE};
            default:      w = '{GATE_NONE, ACT_NOP,       BR_ALWAYS, STEP_CAPTURE};
        endcase
        return w;
    endfunction

    function automatic logic [15:0] rom_len(input logic [1:0] sel);
        logic [15:0] len;
        unique case (sel)
            SRC_ROM0: len = ROM0_LEN;
            SRC_ROM1: len = ROM1_LEN;
            SRC_ROM2: len = ROM2_LEN;
            default:  len = 16'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] rom_byte(input logic [1:0] sel,
                                            input logic [POS_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (sel)
            SRC_ROM0: if (idx < 7'(ROM0_LEN)) b = ROM_IF0[idx[5:0]];
            SRC_ROM1: if (idx < 7'(ROM1_LEN)) b = ROM_IF1[idx];
            SRC_ROM2: if (idx < 7'(ROM2_LEN)) b = ROM_IF2[idx[4:0]];
            default:  b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] reply_byte(input logic [1:0] kind,
                                              input logic [7:0] mid,
                                              input logic [15:0] pid,
                                              input logic [POS_W-1:0] idx);
        logic [7:0]       b;
        logic [POS_W-1:0] off;
        b   = 8'h00;
        off = idx - 7'd3;
        if (kind != KIND_ZERO) begin
            if (idx == 7'd0) begin
                b = mid;
            end else if (kind == KIND_PID) begin
                unique case (idx)
                    7'd1:    b = 8'd5;
                    7'd2:    b = 8'd1;
                    7'd3:    b = pid[7:0];
                    7'd4:    b = pid[15:8];
                    default: b = 8'h00;
                endcase
            end else if (kind == KIND_SERIAL) begin
                if (idx == 7'd1) begin
                    b = 8'd13;
                end else if (idx == 7'd2) begin
                    b = 8'd1;
                end else if (idx >= 7'd3 && idx <= 7'd14) begin
                    b = SERIAL_TEXT[off[3:0]];
                end
            end
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/uhcr_sequencer.sv -----
// uhcr_sequencer: step counter and microprogram lookup with gated steps
// and conditional jumps. Depends on uhcr_pkg.
`default_nettype none

module uhcr_sequencer (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  uhcr_pkg::seq_flags_t         flags,
    output uhcr_pkg::seq_cmd_t           cmd,
    output logic [uhcr_pkg::STEP_W-1:0]  step
);

    logic [uhcr_pkg::STEP_W-1:0] step_reg;
    logic [uhcr_pkg::STEP_W-1:0] step_next;
    uhcr_pkg::ctl_word_t         word;
    logic                        gate_ok;
    logic                        taken;

    always_comb begin
        word = uhcr_pkg::ucode(step_reg);
        unique case (word.gate)
            uhcr_pkg::GATE_IN:  gate_ok = flags.in_valid;
            uhcr_pkg::GATE_OUT: gate_ok = flags.out_free;
            default:            gate_ok = 1'b1;
        endcase
        unique case (word.br)
            uhcr_pkg::BR_ALWAYS: taken = 1'b1;
            uhcr_pkg::BR_STREAM: taken = flags.stream;
            uhcr_pkg::BR_MORE:   taken = flags.more;
            default:             taken = 1'b0;
        endcase
        if (!gate_ok) begin
            step_next = step_reg;
        end else if (taken) begin
            step_next = word.target;
        end else begin
            step_next = step_reg + 3'd1;
        end
        cmd.act = word.act;
        cmd.go  = gate_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= uhcr_pkg::STEP_CAPTURE;
        end else begin
            step_reg <= step_next;
        end
    end

    assign step = step_reg;

endmodule

`default_nettype wire

// ----- hdl/uhcr_datapath.sv -----
// uhcr_datapath: setup capture, request decode, recorded reply state, word
// assembly from descriptor tables or recorded reply, and the result register. Depends on uhcr_pkg.
`default_nettype none

module uhcr_datapath #(
    parameter int FEATURE_REPORT_BYTES = 64
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  uhcr_pkg::seq_cmd_t    cmd,
    output uhcr_pkg::seq_flags_t  flags,
    input  wire [15:0]            product_id,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire [1:0]             s_req_type,
    input  wire [1:0]             s_recipient,
    input  wire [7:0]             s_request_code,
    input  wire [15:0]            s_value_word,
    input  wire [15:0]            s_index_word,
    input  wire [15:0]            s_length_word,
    input  wire                   s_buffer_present,
    input  wire [15:0]            s_buffer_length,
    input  wire [7:0]             s_msg_id,
    input  wire [7:0]             s_arg_len,
    input  wire [7:0]             s_first_arg,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic [1:0]            m_status,
    output logic [15:0]           m_bytes_completed,
    output logic [31:0]           m_data_word,
    output logic [2:0]            m_word_bytes,
    output logic                  m_last
);

    localparam logic [15:0] REPORT_CAP = 16'(FEATURE_REPORT_BYTES);

    typedef struct packed {
        logic        stream;
        logic [1:0]  status;
        logic [15:0] bytes;
        logic        one_byte;
        logic [1:0]  src;
        logic [6:0]  n;
        logic        set_en;
        logic [1:0]  set_kind;
        logic [7:0]  set_mid;
    } dec_t;

    logic [1:0]  type_reg;
    logic [1:0]  recip_reg;
    logic [7:0]  req_reg;
    logic [7:0]  hi_reg;
    logic [15:0] widx_reg;
    logic [15:0] wlen_reg;
    logic        buf_reg;
    logic [15:0] blen_reg;
    logic [7:0]  mid_reg;
    logic [7:0]  alen_reg;
    logic [7:0]  arg0_reg;

    logic        stream_reg;
    logic [1:0]  status_reg;
    logic [15:0] bytes_reg;
    logic        one_byte_reg;
    logic [1:0]  src_reg;
    logic [6:0]  n_reg;
    logic [6:0]  pos_reg;
    logic [1:0]  reply_kind_reg;
    logic [7:0]  reply_mid_reg;

    logic        m_valid_reg;
    logic [1:0]  m_status_reg;
    logic [15:0] m_bytes_reg;
    logic [31:0] m_data_reg;
    logic [2:0]  m_wb_reg;
    logic        m_last_reg;

    dec_t        dec;
    logic [15:0] lim;
    logic [6:0]  rem;
    logic [2:0]  wb;
    logic [31:0] word;
    logic        more;
    logic        emit;

    // request decode from the captured setup
    always_comb begin
        dec          = '0;
        dec.status   = uhcr_pkg::ST_INVALID;
        lim          = 16'd0;
        if (recip_reg == uhcr_pkg::RCP_INTERFACE) begin
            priority if (type_reg == uhcr_pkg::RT_STANDARD) begin
                if (req_reg == uhcr_pkg::REQ_GET_DESCRIPTOR && hi_reg == uhcr_pkg::DESC_REPORT
                        && widx_reg <= 16'd2) begin
                    lim = (wlen_reg < uhcr_pkg::rom_len(widx_reg[1:0]))
                        ? wlen_reg : uhcr_pkg::rom_len(widx_reg[1:0]);
                    if (!buf_reg || blen_reg < lim) begin
                        dec.status = uhcr_pkg::ST_SMALL;
                    end else begin
                        dec.status = uhcr_pkg::ST_OK;
                        dec.stream = (lim != 16'd0);
                        dec.src    = widx_reg[1:0];
                        dec.n      = lim[6:0];
                    end
                end
            end else if (type_reg == uhcr_pkg::RT_CLASS) begin
                unique case (req_reg)
                    uhcr_pkg::REQ_SET_IDLE, uhcr_pkg::REQ_SET_PROTOCOL: begin
                        dec.status = uhcr_pkg::ST_OK;
                    end
                    uhcr_pkg::REQ_SET_REPORT: begin
                        dec.status = uhcr_pkg::ST_OK;
                        if (hi_reg == uhcr_pkg::REPORT_FEATURE && buf_reg) begin
                            dec.set_en = 1'b1;
                            if (blen_reg < 16'd2) begin
                                dec.set_kind = uhcr_pkg::KIND_ZERO;
                                dec.set_mid  = 8'h00;
                            end else begin
                                dec.set_mid = mid_reg;
                                priority if (mid_reg == uhcr_pkg::MSG_PRODUCT_ID) begin
                                    dec.set_kind = uhcr_pkg::KIND_PID;
                                end else if (mid_reg == uhcr_pkg::MSG_SERIAL
                                        && alen_reg >= 8'd1 && blen_reg >= 16'd3
                                        && arg0_reg == 8'd1) begin
                                    dec.set_kind = uhcr_pkg::KIND_SERIAL;
                                end else begin
                                    dec.set_kind = uhcr_pkg::KIND_ACK;
                                end
                            end
                        end
                    end
                    uhcr_pkg::REQ_GET_IDLE, uhcr_pkg::REQ_GET_PROTOCOL: begin
                        if (!buf_reg || blen_reg < 16'd1) begin
                            dec.status = uhcr_pkg::ST_SMALL;
                        end else begin
                            dec.status   = uhcr_pkg::ST_OK;
                            dec.bytes    = 16'd1;
                            dec.one_byte = 1'b1;
                        end
                    end
                    uhcr_pkg::REQ_GET_REPORT: begin
                        if (!buf_reg) begin
                            dec.status = uhcr_pkg::ST_SMALL;
                        end else if (hi_reg == uhcr_pkg::REPORT_FEATURE) begin
                            lim = (wlen_reg < REPORT_CAP) ? wlen_reg : REPORT_CAP;
                            if (blen_reg < lim) begin
                                dec.status = uhcr_pkg::ST_SMALL;
                            end else begin
                                dec.status = uhcr_pkg::ST_OK;
                                dec.stream = (lim != 16'd0);
                                dec.src    = uhcr_pkg::SRC_REPLY;
                                dec.n      = lim[6:0];
                            end
                        end else if (blen_reg < wlen_reg) begin
                            dec.status = uhcr_pkg::ST_SMALL;
                        end else begin
                            dec.status = uhcr_pkg::ST_OK;
                            dec.bytes  = wlen_reg;
                        end
                    end
                    default: dec.status = uhcr_pkg::ST_INVALID;
                endcase
            end else begin
                dec.status = uhcr_pkg::ST_INVALID;
            end
        end
    end

    // one stream word of up to four bytes at pos_reg
    always_comb begin
        rem  = n_reg - pos_reg;
        more = (rem > 7'd4);
        wb   = more ? 3'd4 : rem[2:0];
        word = 32'h0;
        for (int j = 0; j < 4; j++) begin
            if (3'(j) < wb) begin
                if (src_reg == uhcr_pkg::SRC_REPLY) begin
                    word[8*j +: 8] = uhcr_pkg::reply_byte(reply_kind_reg, reply_mid_reg,
                                                          product_id, pos_reg + 7'(j));
                end else begin
                    word[8*j +: 8] = uhcr_pkg::rom_byte(src_reg, pos_reg + 7'(j));
                end
            end
        end
    end

    assign s_ready = (cmd.act == uhcr_pkg::ACT_CAPTURE);
    assign emit    = cmd.go && (cmd.act == uhcr_pkg::ACT_EMIT_ONE
                             || cmd.act == uhcr_pkg::ACT_EMIT_WORD);

    assign flags.in_valid = s_valid;
    assign flags.out_free = !m_valid_reg || m_ready;
    assign flags.stream   = stream_reg;
    assign flags.more     = more;

    always_ff @(posedge aclk) begin
        if (cmd.go && cmd.act == uhcr_pkg::ACT_CAPTURE) begin
            type_reg  <= s_req_type;
            recip_reg <= s_recipient;
            req_reg   <= s_request_code;
            hi_reg    <= s_value_word[15:8];
            widx_reg  <= s_index_word;
            wlen_reg  <= s_length_word;
            buf_reg   <= s_buffer_present;
            blen_reg  <= s_buffer_length;
            mid_reg   <= s_msg_id;
            alen_reg  <= s_arg_len;
            arg0_reg  <= s_first_arg;
        end
        if (cmd.go && cmd.act == uhcr_pkg::ACT_DECODE) begin
            stream_reg   <= dec.stream;
            status_reg   <= dec.status;
            bytes_reg    <= dec.bytes;
            one_byte_reg <= dec.one_byte;
            src_reg      <= dec.src;
            n_reg        <= dec.n;
            pos_reg      <= 7'd0;
        end
        if (emit && cmd.act == uhcr_pkg::ACT_EMIT_WORD) begin
            pos_reg <= pos_reg + 7'd4;
        end
        if (emit) begin
            if (cmd.act == uhcr_pkg::ACT_EMIT_WORD) begin
                m_status_reg <= uhcr_pkg::ST_OK;
                m_bytes_reg  <= {9'd0, n_reg};
                m_data_reg   <= word;
                m_wb_reg     <= wb;
                m_last_reg   <= !more;
            end else begin
                m_status_reg <= status_reg;
                m_bytes_reg  <= bytes_reg;
                m_data_reg   <= 32'h0;
                m_wb_reg     <= one_byte_reg ? 3'd1 : 3'd0;
                m_last_reg   <= 1'b1;
            end
        end
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            reply_kind_reg <= uhcr_pkg::KIND_ZERO;
            reply_mid_reg  <= 8'h00;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.go && cmd.act == uhcr_pkg::ACT_DECODE && dec.set_en) begin
                reply_kind_reg <= dec.set_kind;
                reply_mid_reg  <= dec.set_mid;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_bytes_completed = m_bytes_reg;
    assign m_data_word       = m_data_reg;
    assign m_word_bytes      = m_wb_reg;
    assign m_last            = m_last_reg;

endmodule

`default_nettype wire

// ----- hdl/usb_hid_control_responder_unit.sv -----
// usb_hid_control_responder_unit: top level with the product_id register on
// an apb port. The first result is loaded at the microprogram emit step after
// the setup item is accepted and passes the decode and branch steps, then one
// result item per cycle while the output is not stalled by m_ready. A stream has
// up to 17 result items; the next setup is taken at the capture step.
// Reset (aresetn low, synchronous): sequencer to capture, no result pending,
// recorded reply all-zero with message id 0, product_id 0x1205.
`default_nettype none

module usb_hid_control_responder_unit #(
    parameter int FEATURE_REPORT_BYTES = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_req_type,
    input  wire  [1:0]  s_recipient,
    input  wire  [7:0]  s_request_code,
    input  wire  [15:0] s_value_word,
    input  wire  [15:0] s_index_word,
    input  wire  [15:0] s_length_word,
    input  wire         s_buffer_present,
    input  wire  [15:0] s_buffer_length,
    input  wire  [7:0]  s_msg_id,
    input  wire  [7:0]  s_arg_len,
    input  wire  [7:0]  s_first_arg,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_bytes_completed,
    output logic [31:0] m_data_word,
    output logic [2:0]  m_word_bytes,
    output logic        m_last
);

    logic [15:0]                 product_id_reg;
    uhcr_pkg::seq_cmd_t          cmd;
    uhcr_pkg::seq_flags_t        flags;
    logic [uhcr_pkg::STEP_W-1:0] step;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, product_id_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            product_id_reg <= uhcr_pkg::PRODUCT_ID_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            product_id_reg <= pwdata[15:0];
        end
    end

    uhcr_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .cmd     (cmd),
        .step    (step)
    );

    uhcr_datapath #(
        .FEATURE_REPORT_BYTES (FEATURE_REPORT_BYTES)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .flags             (flags),
        .product_id        (product_id_reg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_recipient       (s_recipient),
        .s_request_code    (s_request_code),
        .s_value_word      (s_value_word),
        .s_index_word      (s_index_word),
        .s_length_word     (s_length_word),
        .s_buffer_present  (s_buffer_present),
        .s_buffer_length   (s_buffer_length),
        .s_msg_id          (s_msg_id),
        .s_arg_len         (s_arg_len),
        .s_first_arg       (s_first_arg),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_bytes_completed (m_bytes_completed),
        .m_data_word       (m_data_word),
        .m_word_bytes      (m_word_bytes),
        .m_last            (m_last)
    );

    // no second setup taken right after one is captured
    a_capture_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready && step == uhcr_pkg::STEP_DECODE))
        else $error("setup item accepted twice in a row");

    // error results are single, empty and final
    a_error_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != uhcr_pkg::ST_OK)
            |-> (m_last && m_bytes_completed == 16'd0 && m_word_bytes == 3'd0))
        else $error("error result carries data or is not last");

    // an item with no valid bytes carries a zero data word
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_word_bytes == 3'd0) |-> (m_data_word == 32'd0))
        else $error("empty result item with nonzero data");

endmodule

`default_nettype wire

// ----- tb/usb_hid_control_responder_unit_tb.sv -----
// usb_hid_control_responder_unit_tb: self-checking bench for the hid control responder.
// Drives setup items and apb writes, predicts every result item in a scoreboard class.
// Depends on uhcr_pkg and usb_hid_control_responder_unit.
`default_nettype none

module usb_hid_control_responder_unit_tb;
    import uhcr_pkg::*;

    localparam logic [1:0] RT_VENDOR     = 2'd2;
    localparam logic [1:0] RT_RESERVED   = 2'd3;
    localparam logic [1:0] RCP_DEVICE    = 2'd0;
    localparam logic [7:0] REPORT_INPUT  = 8'h01;
    localparam logic [7:0] REPORT_OUTPUT = 8'h02;
    localparam logic [7:0] DESC_HID      = 8'h21;
    localparam logic [7:0] REQ_UNUSED    = 8'hFF;
    localparam logic [2:0] ADDR_PRODUCT_ID = 3'd0;
    localparam int FEATURE_BYTES  = 64;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [7:0] DESC_IF0 [0:38] = '{
        8'h05, 8'h01, 8'h09, 8'h06, 8'hA1, 8'h01, 8'h05, 8'h07, 8'h19, 8'hE0, 8'h29, 8'hE7,
        8'h15, 8'h00, 8'h25, 8'h01, 8'h75, 8'h01, 8'h95, 8'h08, 8'h81, 8'h02, 8'h81, 8'h01,
        8'h19, 8'h00, 8'h29, 8'h65, 8'h15, 8'h00, 8'h25, 8'h65, 8'h75, 8'h08, 8'h95, 8'h06,
        8'h81, 8'h00, 8'hC0
    };
    localparam logic [7:0] DESC_IF1 [0:64] = '{
        8'h05, 8'h01, 8'h09, 8'h02, 8'hA1, 8'h01, 8'h09, 8'h01, 8'hA1, 8'h00, 8'h05, 8'h09,
        8'h19, 8'h01, 8'h29, 8'h02, 8'h15, 8'h00, 8'h25, 8'h01, 8'h75, 8'h01, 8'h95, 8'h02,
        8'h81, 8'h02, 8'h75, 8'h06, 8'h95, 8'h01, 8'h81, 8'h01, 8'h05, 8'h01, 8'h09, 8'h30,
        8'h09, 8'h31, 8'h15, 8'h81, 8'h25, 8'h7F, 8'h75, 8'h08, 8'h95, 8'h02, 8'h81, 8'h06,
        8'h95, 8'h01, 8'h09, 8'h38, 8'h81, 8'h06, 8'h05, 8'h0C, 8'h0A, 8'h38, 8'h02, 8'h95,
        8'h01, 8'h81, 8'h06, 8'hC0, 8'hC0
    };
    localparam logic [7:0] DESC_IF2 [0:28] = '{
        8'h06, 8'hFF, 8'hFF, 8'h09, 8'h01, 8'hA1, 8'h01, 8'h15, 8'h00, 8'h26, 8'hFF, 8'h00,
        8'h75, 8'h08, 8'h95, 8'h40, 8'h09, 8'h01, 8'h81, 8'h02, 8'h09, 8'h01, 8'h91, 8'h02,
        8'h09, 8'h01, 8'hB1, 8'h02, 8'hC0
    };
    localparam logic [7:0] SERIAL_ASCII [0:11] = '{
        "M", "E", "D", "A", "0", "0", "0", "0", "0", "0", "0", "1"
    };

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  recipient;
        logic [7:0]  request_code;
        logic [15:0] value_word;
        logic [15:0] index_word;
        logic [15:0] length_word;
        logic        buffer_present;
        logic [15:0] buffer_length;
        logic [7:0]  msg_id;
        logic [7:0]  arg_len;
        logic [7:0]  first_arg;
    } setup_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] bytes_completed;
        logic [31:0] data_word;
        logic [2:0]  word_bytes;
        logic        last;
    } reply_t;

    class hid_reply_scoreboard;
        logic [15:0] product_id   = PRODUCT_ID_RESET;
        logic [7:0]  reply_msg_id = 8'h00;
        logic [1:0]  reply_kind   = KIND_ZERO;
        logic [7:0]  stage [0:79];
        reply_t      expected_replies [$];
        int          errors = 0;

        function int pending();
            return expected_replies.size();
        endfunction

        function void add_single(logic [1:0] st, logic [15:0] nbytes);
            reply_t r;
            r.status          = st;
            r.bytes_completed = (st == ST_OK) ? nbytes : 16'd0;
            r.data_word       = '0;
            r.word_bytes      = '0;
            r.last            = 1'b1;
            expected_replies.push_back(r);
        endfunction

        function void add_stream(int n);
            reply_t r;
            int pos;
            int wb;
            int j;
            if (n == 0) begin
                add_single(ST_OK, 16'd0);
                return;
            end
            pos = 0;
            while (pos < n) begin
                wb = (n - pos > 4) ? 4 : n - pos;
                r.status          = ST_OK;
                r.bytes_completed = 16'(n);
                r.data_word       = '0;
                for (j = 0; j < wb; j++)
                    r.data_word[8*j +: 8] = stage[pos + j];
                r.word_bytes = 3'(wb);
                pos += wb;
                r.last = (pos >= n);
                expected_replies.push_back(r);
            end
        endfunction

        function void load_descriptor(int sel, int n);
            int i;
            for (i = 0; i < n; i++) begin
                case (sel)
                    0:       stage[i] = DESC_IF0[i];
                    1:       stage[i] = DESC_IF1[i];
                    default: stage[i] = DESC_IF2[i];
                endcase
            end
        endfunction

        function void load_reply();
            int i;
            for (i = 0; i < 80; i++)
                stage[i] = 8'h00;
            if (reply_kind == KIND_ZERO)
                return;
            stage[0] = reply_msg_id;
            if (reply_kind == KIND_PID) begin
                stage[1] = 8'd5;
                stage[2] = 8'd1;
                stage[3] = product_id[7:0];
                stage[4] = product_id[15:8];
            end else if (reply_kind == KIND_SERIAL) begin
                stage[1] = 8'd13;
                stage[2] = 8'd1;
                for (i = 0; i < 12; i++)
                    stage[3 + i] = SERIAL_ASCII[i];
            end
        endfunction

        function void note_setup(setup_t s);
            logic [7:0] hi;
            int len;
            int n;
            hi = s.value_word[15:8];
            if (s.recipient != RCP_INTERFACE) begin
                add_single(ST_INVALID, 16'd0);
                return;
            end
            if (s.req_type == RT_STANDARD) begin
                if (s.request_code != REQ_GET_DESCRIPTOR || hi != DESC_REPORT
                        || s.index_word > 16'd2) begin
                    add_single(ST_INVALID, 16'd0);
                    return;
                end
                case (s.index_word)
                    16'd0:   len = $size(DESC_IF0);
                    16'd1:   len = $size(DESC_IF1);
                    default: len = $size(DESC_IF2);
                endcase
                n = (int'(s.length_word) < len) ? int'(s.length_word) : len;
                if (!s.buffer_present || int'(s.buffer_length) < n) begin
                    add_single(ST_SMALL, 16'd0);
                    return;
                end
                load_descriptor(int'(s.index_word), n);
                add_stream(n);
                return;
            end
            if (s.req_type != RT_CLASS) begin
                add_single(ST_INVALID, 16'd0);
                return;
            end
            case (s.request_code)
                REQ_SET_IDLE, REQ_SET_PROTOCOL: add_single(ST_OK, 16'd0);
                REQ_SET_REPORT: begin
                    if (hi == REPORT_FEATURE && s.buffer_present) begin
                        if (s.buffer_length < 16'd2) begin
                            reply_msg_id = 8'h00;
                            reply_kind   = KIND_ZERO;
                        end else begin
                            reply_msg_id = s.msg_id;
                            if (s.msg_id == MSG_PRODUCT_ID)
                                reply_kind = KIND_PID;
                            else if (s.msg_id == MSG_SERIAL && s.arg_len >= 8'd1
                                    && s.buffer_length >= 16'd3 && s.first_arg == 8'd1)
                                reply_kind = KIND_SERIAL;
                            else
                                reply_kind = KIND_ACK;
                        end
                    end
                    add_single(ST_OK, 16'd0);
                end
                REQ_GET_IDLE, REQ_GET_PROTOCOL: begin
                    if (!s.buffer_present || s.buffer_length < 16'd1) begin
                        add_single(ST_SMALL, 16'd0);
                    end else begin
                        stage[0] = 8'h00;
                        add_stream(1);
                    end
                end
                REQ_GET_REPORT: begin
                    if (!s.buffer_present) begin
                        add_single(ST_SMALL, 16'd0);
                    end else if (hi == REPORT_FEATURE) begin
                        n = (int'(s.length_word) < FEATURE_BYTES) ? int'(s.length_word)
                                                                   : FEATURE_BYTES;
                        if (int'(s.buffer_length) < n) begin
                            add_single(ST_SMALL, 16'd0);
                        end else begin
                            load_reply();
                            add_stream(n);
                        end
                    end else if (s.buffer_length < s.length_word) begin
                        add_single(ST_SMALL, 16'd0);
                    end else begin
                        add_single(ST_OK, s.length_word);
                    end
                end
                default: add_single(ST_INVALID, 16'd0);
            endcase
        endfunction

        function void compare_field(string fname, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", fname, want, got);
                errors++;
            end
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (expected_replies.size() == 0) begin
                $error("result item with nothing expected: status %0h data_word %0h",
                       got.status, got.data_word);
                errors++;
                return;
            end
            want = expected_replies.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("bytes_completed", 32'(want.bytes_completed),
                          32'(got.bytes_completed));
            compare_field("data_word", want.data_word, got.data_word);
            compare_field("word_bytes", 32'(want.word_bytes), 32'(got.word_bytes));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [1:0]  s_recipient;
    logic [7:0]  s_request_code;
    logic [15:0] s_value_word;
    logic [15:0] s_index_word;
    logic [15:0] s_length_word;
    logic        s_buffer_present;
    logic [15:0] s_buffer_length;
    logic [7:0]  s_msg_id;
    logic [7:0]  s_arg_len;
    logic [7:0]  s_first_arg;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [15:0] m_bytes_completed;
    logic [31:0] m_data_word;
    logic [2:0]  m_word_bytes;
    logic        m_last;

    hid_reply_scoreboard sb;
    bit idle_on = 1'b0;
    int quiet_cycles = 0;
    int stall_left = 0;

    usb_hid_control_responder_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_recipient(s_recipient),
        .s_request_code(s_request_code), .s_value_word(s_value_word),
        .s_index_word(s_index_word), .s_length_word(s_length_word),
        .s_buffer_present(s_buffer_present), .s_buffer_length(s_buffer_length),
        .s_msg_id(s_msg_id), .s_arg_len(s_arg_len), .s_first_arg(s_first_arg),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_bytes_completed(m_bytes_completed),
        .m_data_word(m_data_word), .m_word_bytes(m_word_bytes), .m_last(m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic setup_t mk_setup(logic [1:0] rt, logic [1:0] rcp, logic [7:0] code,
                                        logic [15:0] wval, logic [15:0] widx,
                                        logic [15:0] wlen, logic bp, logic [15:0] blen,
                                        logic [7:0] mid, logic [7:0] alen, logic [7:0] arg);
        setup_t s;
        s = '{rt, rcp, code, wval, widx, wlen, bp, blen, mid, alen, arg};
        return s;
    endfunction

    function automatic logic [15:0] rand_length();
        return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 72));
    endfunction

    function automatic setup_t random_setup();
        setup_t s;
        bit blen_done;
        s.req_type       = 2'($urandom);
        s.recipient      = 2'($urandom);
        s.request_code   = 8'($urandom);
        s.value_word     = 16'($urandom);
        s.index_word     = 16'($urandom);
        s.length_word    = 16'($urandom);
        s.buffer_present = 1'($urandom);
        s.buffer_length  = 16'($urandom);
        s.msg_id         = 8'($urandom);
        s.arg_len        = 8'($urandom);
        s.first_arg      = 8'($urandom);
        blen_done = 1'b0;
        if ($urandom_range(0, 9) == 0)
            return s;
        if ($urandom_range(0, 15) != 0)
            s.recipient = RCP_INTERFACE;
        s.buffer_present = ($urandom_range(0, 9) != 0);
        s.length_word = rand_length();
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                s.req_type = RT_STANDARD;
                s.request_code = REQ_GET_DESCRIPTOR;
                if ($urandom_range(0, 9) != 0)
                    s.value_word[15:8] = DESC_REPORT;
                if ($urandom_range(0, 9) != 0)
                    s.index_word = 16'($urandom_range(0, 2));
            end
            3, 4: begin
                s.req_type = RT_CLASS;
                s.request_code = REQ_SET_REPORT;
                if ($urandom_range(0, 7) != 0)
                    s.value_word[15:8] = REPORT_FEATURE;
                case ($urandom_range(0, 3))
                    0:       s.msg_id = MSG_PRODUCT_ID;
                    1, 2:    s.msg_id = MSG_SERIAL;
                    default: ;
                endcase
                if ($urandom_range(0, 1) != 0)
                    s.arg_len = 8'($urandom_range(0, 2));
                if ($urandom_range(0, 1) != 0)
                    s.first_arg = 8'($urandom_range(0, 2));
                if ($urandom_range(0, 3) != 0)
                    s.buffer_length = 16'($urandom_range(0, 5));
                blen_done = 1'b1;
            end
            5, 6: begin
                s.req_type = RT_CLASS;
                s.request_code = REQ_GET_REPORT;
                if ($urandom_range(0, 3) != 0)
                    s.value_word[15:8] = REPORT_FEATURE;
            end
            7: begin
                s.req_type = RT_CLASS;
                s.request_code = ($urandom_range(0, 1) != 0) ? REQ_GET_IDLE : REQ_GET_PROTOCOL;
                s.length_word = 16'($urandom_range(0, 2));
            end
            8: begin
                s.req_type = RT_CLASS;
                s.request_code = ($urandom_range(0, 1) != 0) ? REQ_SET_IDLE : REQ_SET_PROTOCOL;
            end
            default: s.req_type = RT_CLASS;
        endcase
        if (!blen_done) begin
            case ($urandom_range(0, 7))
                0:       s.buffer_length = 16'($urandom);
                1:       s.buffer_length = s.length_word - 16'd1;
                default: s.buffer_length = (s.length_word > 16'hFFF0) ? 16'hFFFF
                                           : s.length_word + 16'($urandom_range(0, 8));
            endcase
        end
        return s;
    endfunction

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_setup(setup_t s);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_req_type       <= s.req_type;
        s_recipient      <= s.recipient;
        s_request_code   <= s.request_code;
        s_value_word     <= s.value_word;
        s_index_word     <= s.index_word;
        s_length_word    <= s.length_word;
        s_buffer_present <= s.buffer_present;
        s_buffer_length  <= s.buffer_length;
        s_msg_id         <= s.msg_id;
        s_arg_len        <= s.arg_len;
        s_first_arg      <= s.first_arg;
        do @(posedge aclk); while (!s_ready);
        sb.note_setup(s);
    endtask

    // drain all results, then reprogram product_id while the block is idle
    task automatic set_product_id(logic [15:0] pid);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_PRODUCT_ID;
        pwdata  <= {16'h0000, pid};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.product_id = pid;
    endtask

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 11);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= aresetn;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_reply(reply_t'{m_status, m_bytes_completed, m_data_word,
                                    m_word_bytes, m_last});
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("usb_hid_control_responder_unit_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        sb = new;
        aresetn          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        s_valid          <= 1'b0;
        s_req_type       <= '0;
        s_recipient      <= '0;
        s_request_code   <= '0;
        s_value_word     <= '0;
        s_index_word     <= '0;
        s_length_word    <= '0;
        s_buffer_present <= 1'b0;
        s_buffer_length  <= '0;
        s_msg_id         <= '0;
        s_arg_len        <= '0;
        s_first_arg      <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_product_id(PRODUCT_ID_RESET);
        idle_on = 1'b1;

        send_setup(mk_setup(RT_STANDARD, RCP_DEVICE, REQ_GET_DESCRIPTOR, {DESC_REPORT, 8'h00},
                            16'd0, 16'hFFFF, 1'b1, 16'hFFFF, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_STANDARD, RCP_INTERFACE, REQ_GET_DESCRIPTOR, {DESC_REPORT, 8'h00},
                            16'd0, 16'hFFFF, 1'b1, 16'hFFFF, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_STANDARD, RCP_INTERFACE, REQ_GET_DESCRIPTOR, {DESC_REPORT, 8'hFF},
                            16'd1, 16'd65, 1'b1, 16'd65, 8'hFF, 8'hFF, 8'hFF));
        send_setup(mk_setup(RT_STANDARD, RCP_INTERFACE, REQ_GET_DESCRIPTOR, {DESC_REPORT, 8'h00},
                            16'd2, 16'd7, 1'b1, 16'd7, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_STANDARD, RCP_INTERFACE, REQ_GET_DESCRIPTOR, {DESC_REPORT, 8'h00},
                            16'hFFFF, 16'd8, 1'b1, 16'd8, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_STANDARD, RCP_INTERFACE, REQ_GET_DESCRIPTOR, {DESC_HID, 8'h00},
                            16'd0, 16'd8, 1'b1, 16'd8, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_STANDARD, RCP_INTERFACE, REQ_GET_DESCRIPTOR, {DESC_REPORT, 8'h00},
                            16'd0, 16'd0, 1'b1, 16'd0, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_STANDARD, RCP_INTERFACE, REQ_GET_DESCRIPTOR, {DESC_REPORT, 8'h00},
                            16'd2, 16'd29, 1'b0, 16'd29, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_STANDARD, RCP_INTERFACE, REQ_GET_DESCRIPTOR, {DESC_REPORT, 8'h00},
                            16'd1, 16'd20, 1'b1, 16'd10, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_CLASS, RCP_INTERFACE, REQ_SET_IDLE, 16'h0000,
                            16'd0, 16'd0, 1'b0, 16'd0, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_CLASS, RCP_INTERFACE, REQ_SET_PROTOCOL, 16'h0001,
                            16'd1, 16'd0, 1'b0, 16'd0, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_CLASS, RCP_INTERFACE, REQ_GET_REPORT, {REPORT_FEATURE, 8'h00},
                            16'd2, 16'd64, 1'b1, 16'd64, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_CLASS, RCP_INTERFACE, REQ_SET_REPORT, {REPORT_FEATURE, 8'h00},
                            16'd2, 16'd2, 1'b1, 16'd2, MSG_PRODUCT_ID, 8'h00, 8'h00));
        send_setup(mk_setup(RT_CLASS, RCP_INTERFACE, REQ_GET_REPORT, {REPORT_FEATURE, 8'h00},
                            16'd2, 16'hFFFF, 1'b1, 16'hFFFF, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_CLASS, RCP_INTERFACE, REQ_SET_REPORT, {REPORT_FEATURE, 8'h00},
                            16'd2, 16'd3, 1'b1, 16'd3, MSG_SERIAL, 8'd1, 8'd1));
        send_setup(mk_setup(RT_CLASS, RCP_INTERFACE, REQ_GET_REPORT, {REPORT_FEATURE, 8'h00},
                            16'd2, 16'd20, 1'b1, 16'd20, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_CLASS, RCP_INTERFACE, REQ_SET_REPORT, {REPORT_FEATURE, 8'h00},
                            16'd2, 16'd3, 1'b1, 16'd3, MSG_SERIAL, 8'd0, 8'd1));
        send_setup(mk_setup(RT_CLASS, RCP_INTERFACE, REQ_GET_REPORT, {REPORT_FEATURE, 8'h00},
                            16'd2, 16'd5, 1'b1, 16'd5, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_CLASS, RCP_INTERFACE, REQ_SET_REPORT, {REPORT_FEATURE, 8'h00},
                            16'd2, 16'd1, 1'b1, 16'd1, 8'h42, 8'h00, 8'h00));
        send_setup(mk_setup(RT_CLASS, RCP_INTERFACE, REQ_SET_REPORT, {REPORT_OUTPUT, 8'h00},
                            16'd2, 16'd8, 1'b1, 16'd8, MSG_PRODUCT_ID, 8'h00, 8'h00));
        send_setup(mk_setup(RT_CLASS, RCP_INTERFACE, REQ_GET_REPORT, {REPORT_FEATURE, 8'h00},
                            16'd2, 16'd3, 1'b1, 16'd3, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_CLASS, RCP_INTERFACE, REQ_GET_IDLE, 16'h0000,
                            16'd0, 16'd1, 1'b1, 16'd1, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_CLASS, RCP_INTERFACE, REQ_GET_PROTOCOL, 16'h0000,
                            16'd0, 16'd1, 1'b0, 16'd1, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_CLASS, RCP_INTERFACE, REQ_GET_REPORT, {REPORT_INPUT, 8'h00},
                            16'd0, 16'd100, 1'b1, 16'd100, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_CLASS, RCP_INTERFACE, REQ_GET_REPORT, {REPORT_INPUT, 8'h00},
                            16'd0, 16'd100, 1'b1, 16'd99, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_VENDOR, RCP_INTERFACE, REQ_GET_REPORT, {REPORT_FEATURE, 8'h00},
                            16'd0, 16'd4, 1'b1, 16'd4, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_RESERVED, RCP_INTERFACE, REQ_SET_IDLE, 16'h0000,
                            16'd0, 16'd0, 1'b1, 16'd0, 8'h00, 8'h00, 8'h00));
        send_setup(mk_setup(RT_CLASS, RCP_INTERFACE, REQ_UNUSED, 16'hFFFF,
                            16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));

        set_product_id(16'hFFFF);
        repeat (125) send_setup(random_setup());
        set_product_id(16'h0000);
        repeat (125) send_setup(random_setup());
        set_product_id(16'($urandom));
        repeat (100) send_setup(random_setup());
        idle_on = 1'b0;
        repeat (45) send_setup(random_setup());

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0)
            $display("usb_hid_control_responder_unit_tb: clean");
        else
            $display("usb_hid_control_responder_unit_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
